// ===== rtl/countdown_timer_seven_segment_assert.svh =====
// assertion macros for the countdown timer rtl
// expects clk and rst in the scope of each use
`ifndef COUNTDOWN_TIMER_SEVEN_SEGMENT_ASSERT_SVH
`define COUNTDOWN_TIMER_SEVEN_SEGMENT_ASSERT_SVH

`ifndef SYNTH
`define CTSS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("countdown timer check failed");
`define CTSS_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("countdown timer check failed");
`else
`define CTSS_ASSERT(lbl, prop)
`define CTSS_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// ===== rtl/ctss_pkg.sv =====
`timescale 1ns / 1ps
// shared types, opcodes and seven-segment encoding for the countdown timer
// no dependencies
package ctss_pkg;

  localparam int SwW = 10;
  localparam int OpW = 3;
  localparam int SegPairW = 16;

  localparam int HundredthsW = 7;
  localparam int HundredthsMax = 99;
  localparam int SecondsW = 6;
  localparam int SecondsMax = 59;
  localparam int MinutesW = 6;
  localparam int MinutesMax = 59;

  localparam logic [OpW-1:0] OP_TICK       = 3'd0;
  localparam logic [OpW-1:0] OP_START_STOP = 3'd1;
  localparam logic [OpW-1:0] OP_SET_HUND   = 3'd2;
  localparam logic [OpW-1:0] OP_SET_SEC    = 3'd3;
  localparam logic [OpW-1:0] OP_SET_MIN    = 3'd4;

  typedef struct packed {
    logic load;
    logic borrow;
  } cell_ctrl_t;

  typedef struct packed {
    logic zero;
    logic borrow;
  } cell_stat_t;

  // gfedcba
  function automatic logic [6:0] seg_digit(input logic [3:0] d);
    logic [6:0] s;
    case (d)
      4'd0: s = 7'h3F;
      4'd1: s = 7'h06;
      4'd2: s = 7'h5B;
      4'd3: s = 7'h4F;
      4'd4: s = 7'h66;
      4'd5: s = 7'h6D;
      4'd6: s = 7'h7D;
      4'd7: s = 7'h07;
      4'd8: s = 7'h7F;
      4'd9: s = 7'h67;
      default: s = 7'h3F;
    endcase
    return s;
  endfunction

  // two digits, tens in the upper byte; values never exceed 99
  function automatic logic [SegPairW-1:0] seg_pair(input logic [6:0] v);
    logic [3:0] tens;
    logic [6:0] ones;
    tens = 4'd0;
    for (int i = 1; i < 10; i++) begin
      if (v >= 7'(10 * i)) tens = 4'(i);
    end
    ones = v - 7'(10 * int'(tens));
    return {1'b0, seg_digit(tens), 1'b0, seg_digit(ones[3:0])};
  endfunction

endpackage

// ===== rtl/ctss_cell.sv =====
`timescale 1ns / 1ps
// one digit-pair counter cell of the countdown chain: load, decrement, wrap
// depends on ctss_pkg
module ctss_cell import ctss_pkg::*; #(
  parameter int Width = 7,
  parameter int MaxValue = 99
) (
  input  logic                clk,
  input  logic                rst,
  input  cell_ctrl_t          ctrl,
  input  logic [SwW-1:0]      load_value,
  output cell_stat_t          stat,
  output logic [SegPairW-1:0] seg
);

  logic [Width-1:0] value;
  logic [Width-1:0] value_next;
  logic [Width-1:0] load_sat;

  assign load_sat = (load_value > SwW'(MaxValue)) ? Width'(MaxValue)
                                                   : load_value[Width-1:0];

  always_comb begin
    value_next = value;
    if (ctrl.load) begin
      value_next = load_sat;
    end else if (ctrl.borrow) begin
      value_next = (value == '0) ? Width'(MaxValue) : value - Width'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= Width'(MaxValue);
    end else begin
      value <= value_next;
    end
  end

  assign stat.zero   = (value == '0);
  // borrow passes on to the next cell when this one wraps
  assign stat.borrow = ctrl.borrow & (value == '0);
  assign seg         = seg_pair(7'(value));

endmodule

// ===== rtl/countdown_timer_seven_segment.sv =====
`timescale 1ns / 1ps
// Minutes:seconds:hundredths countdown timer with seven-segment output. Each input
// beat (opcode in tuser, switch value in tdata) yields exactly one output beat with
// the six encoded digits and the run flag after that beat. One beat is taken per
// clock: the three digit-pair counters update in the accepting cycle, borrowing
// along the chain, and the result is presented from the next cycle on. Throughput
// is set by the single output stage; it holds one beat while the sink stalls.
// Reset loads 59:59:99 and starts running.
`include "countdown_timer_seven_segment_assert.svh"

module countdown_timer_seven_segment import ctss_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [9:0] switch_value, [15:10] zero
  input  logic [7:0]  s_axis_tuser,  // [2:0] opcode, [7:3] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // [30:0] display_low, [45:31] display_high,
                                     // [46] running, [47] zero
);

  logic           accept;
  logic [OpW-1:0] opcode;
  logic [SwW-1:0] switch_value;
  logic           running;
  logic           running_next;
  logic           time_left;
  logic           tick_go;

  cell_ctrl_t hund_ctrl, sec_ctrl, min_ctrl;
  cell_stat_t hund_stat, sec_stat, min_stat;
  logic [SegPairW-1:0] hund_seg, sec_seg, min_seg;

  assign s_axis_tready = ~m_axis_tvalid | m_axis_tready;
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign opcode        = s_axis_tuser[OpW-1:0];
  assign switch_value  = s_axis_tdata[SwW-1:0];

  assign time_left = ~(hund_stat.zero & sec_stat.zero & min_stat.zero);
  assign tick_go   = accept & (opcode == OP_TICK) & running & time_left;

  assign hund_ctrl.load   = accept & (opcode == OP_SET_HUND);
  assign hund_ctrl.borrow = tick_go;
  assign sec_ctrl.load    = accept & (opcode == OP_SET_SEC);
  assign sec_ctrl.borrow  = hund_stat.borrow;
  assign min_ctrl.load    = accept & (opcode == OP_SET_MIN);
  assign min_ctrl.borrow  = sec_stat.borrow;

  ctss_cell #(.Width(HundredthsW), .MaxValue(HundredthsMax)) u_hund (
    .clk(clk), .rst(rst), .ctrl(hund_ctrl), .load_value(switch_value),
    .stat(hund_stat), .seg(hund_seg)
  );

  ctss_cell #(.Width(SecondsW), .MaxValue(SecondsMax)) u_sec (
    .clk(clk), .rst(rst), .ctrl(sec_ctrl), .load_value(switch_value),
    .stat(sec_stat), .seg(sec_seg)
  );

  ctss_cell #(.Width(MinutesW), .MaxValue(MinutesMax)) u_min (
    .clk(clk), .rst(rst), .ctrl(min_ctrl), .load_value(switch_value),
    .stat(min_stat), .seg(min_seg)
  );

  always_comb begin
    running_next = running;
    if (accept) begin
      case (opcode)
        OP_TICK: begin
          // a tick at zero while running stops the timer
          if (running && !time_left) running_next = 1'b0;
        end
        OP_START_STOP: begin
          if (time_left) running_next = ~running;
        end
        default: running_next = running;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running       <= 1'b1;
      m_axis_tvalid <= 1'b0;
    end else begin
      running <= running_next;
      if (accept) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // state only moves on an accepted beat, so the display is read straight off the cells
  assign m_axis_tdata = {1'b0, running, min_seg[14:0], sec_seg[14:0], hund_seg};

  `CTSS_ASSERT_NEXT(a_stop_at_zero,
    accept && opcode == OP_TICK && running && !time_left, !running)
  `CTSS_ASSERT_NEXT(a_zero_sticks,
    !time_left && !(accept && (opcode == OP_SET_HUND || opcode == OP_SET_SEC ||
    opcode == OP_SET_MIN)), !time_left)
  `CTSS_ASSERT_NEXT(a_beat_out, accept, m_axis_tvalid)

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// self-checking bench for the countdown timer: directed rows, then random beats
// with bursts of idling on both streams; needs ctss_pkg and countdown_timer_seven_segment
module testbench;
  import ctss_pkg::*;

  // opcodes the block leaves unused
  localparam logic [OpW-1:0] OP_SPARE_A = 3'd5;
  localparam logic [OpW-1:0] OP_SPARE_B = 3'd6;
  localparam logic [OpW-1:0] OP_SPARE_C = 3'd7;

  localparam int RandomBeats = 900;
  localparam int CalmAfter   = 800;

  // gfedcba glyphs for 0..9
  localparam logic [6:0] GLYPH [10] = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66,
                                        7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h67};

  typedef struct packed {
    logic        running;
    logic [14:0] high;
    logic [30:0] low;
  } readout_t;

  typedef struct {
    logic [OpW-1:0] op;
    logic [SwW-1:0] sw;
    bit             typed;
    readout_t       want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // [9:0] switch_value
  logic [7:0]  s_axis_tuser = '0;  // [2:0] opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;       // [30:0] display_low, [45:31] display_high, [46] running

  countdown_timer_seven_segment dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // predicted timer state
  logic [HundredthsW-1:0] hund_q = 7'(HundredthsMax);
  logic [SecondsW-1:0]    sec_q  = 6'(SecondsMax);
  logic [MinutesW-1:0]    min_q  = 6'(MinutesMax);
  logic                   run_q  = 1'b1;

  readout_t pending_readouts[$];
  row_t     directed_rows[$];
  int       mismatches = 0;
  bit       calm = 1'b0;
  int       sink_hold = 0;

  function automatic logic [15:0] glyph_pair(input int v);
    return {1'b0, GLYPH[(v / 10) % 10], 1'b0, GLYPH[v % 10]};
  endfunction

  task automatic advance_timer(input logic [OpW-1:0] op, input logic [SwW-1:0] sw,
                               output readout_t r);
    logic [31:0] low_word;
    logic [15:0] high_word;
    bit          left;
    left = (hund_q | sec_q | min_q) != 0;
    case (op)
      OP_TICK: begin
        if (run_q) begin
          if (!left) begin
            run_q = 1'b0;
          end else if (hund_q != 0) begin
            hund_q = hund_q - 1'b1;
          end else begin
            hund_q = 7'(HundredthsMax);
            if (sec_q != 0) begin
              sec_q = sec_q - 1'b1;
            end else begin
              sec_q = 6'(SecondsMax);
              if (min_q != 0) min_q = min_q - 1'b1;
            end
          end
        end
      end
      OP_START_STOP: if (left) run_q = ~run_q;
      OP_SET_HUND:   hund_q = (sw > HundredthsMax) ? 7'(HundredthsMax) : 7'(sw);
      OP_SET_SEC:    sec_q = (sw > SecondsMax) ? 6'(SecondsMax) : 6'(sw);
      OP_SET_MIN:    min_q = (sw > MinutesMax) ? 6'(MinutesMax) : 6'(sw);
      default: ;
    endcase
    low_word  = {glyph_pair(int'(sec_q)), glyph_pair(int'(hund_q))};
    high_word = glyph_pair(int'(min_q));
    r.low     = low_word[30:0];
    r.high    = high_word[14:0];
    r.running = run_q;
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t %s: got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic send_beat(input logic [OpW-1:0] op, input logic [SwW-1:0] sw,
                           input bit typed, input readout_t want);
    readout_t predicted;
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= 16'(sw);
    s_axis_tuser  <= 8'(op);
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    advance_timer(op, sw, predicted);
    pending_readouts.push_back(typed ? want : predicted);
  endtask

  task automatic add_row(input logic [OpW-1:0] op, input logic [SwW-1:0] sw, input bit typed,
                         input logic [30:0] low, input logic [14:0] high, input logic running);
    row_t r;
    r.op = op;
    r.sw = sw;
    r.typed = typed;
    r.want.low = low;
    r.want.high = high;
    r.want.running = running;
    directed_rows.push_back(r);
  endtask

  // countdown burst: load 0 or 1 minutes and seconds and 0 to 6 hundredths, make sure it runs, then send 1 to 10 ticks
  task automatic countdown_burst(inout int sent);
    int n;
    send_beat(OP_SET_MIN, 10'($urandom_range(0, 1)), 1'b0, '0);
    send_beat(OP_SET_SEC, 10'($urandom_range(0, 1)), 1'b0, '0);
    send_beat(OP_SET_HUND, 10'($urandom_range(0, 6)), 1'b0, '0);
    sent += 3;
    if (!run_q) begin
      send_beat(OP_START_STOP, 10'($urandom), 1'b0, '0);
      sent++;
    end
    n = $urandom_range(1, 10);
    repeat (n) begin
      send_beat(OP_TICK, 10'($urandom), 1'b0, '0);
      sent++;
    end
  endtask

  task automatic random_beat();
    logic [OpW-1:0] op;
    logic [SwW-1:0] sw;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) op = OP_TICK;
    else if (pick < 55) op = OP_START_STOP;
    else if (pick < 65) op = OP_SET_HUND;
    else if (pick < 75) op = OP_SET_SEC;
    else if (pick < 85) op = OP_SET_MIN;
    else op = 3'($urandom_range(OP_SPARE_A, OP_SPARE_C));
    case ($urandom_range(0, 3))
      0: sw = 10'($urandom_range(0, 3));
      1: sw = 10'($urandom_range(55, 100));
      default: sw = 10'($urandom);
    endcase
    send_beat(op, sw, 1'b0, '0);
  endtask

  // sink side: random stall bursts
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      sink_hold <= $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    readout_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_readouts.size() == 0) begin
        report_mismatch("unexpected beat", longint'(m_axis_tdata), 0);
      end else begin
        want = pending_readouts.pop_front();
        if (m_axis_tdata[30:0] != want.low)
          report_mismatch("display_low", m_axis_tdata[30:0], want.low);
        if (m_axis_tdata[45:31] != want.high)
          report_mismatch("display_high", m_axis_tdata[45:31], want.high);
        if (m_axis_tdata[46] != want.running)
          report_mismatch("running", m_axis_tdata[46], want.running);
      end
    end
  end

  initial begin
    #5ms;
    $display("countdown_timer_seven_segment: mismatch");
    $finish;
  end

  initial begin
    int sent;
    sent = 0;
    // from reset 59:59:99 running
    add_row(OP_TICK,       10'd0,    1'b1, 31'h6D67677F, 15'h6D67, 1'b1);
    add_row(OP_SET_HUND,   10'd1023, 1'b1, 31'h6D676767, 15'h6D67, 1'b1);
    add_row(OP_SET_SEC,    10'd0,    1'b0, '0, '0, 1'b0);
    add_row(OP_SET_MIN,    10'd0,    1'b0, '0, '0, 1'b0);
    add_row(OP_SET_HUND,   10'd0,    1'b1, 31'h3F3F3F3F, 15'h3F3F, 1'b1);
    // start/stop with no time left is ignored
    add_row(OP_START_STOP, 10'd0,    1'b1, 31'h3F3F3F3F, 15'h3F3F, 1'b1);
    // tick at zero while running stops the timer
    add_row(OP_TICK,       10'd0,    1'b1, 31'h3F3F3F3F, 15'h3F3F, 1'b0);
    add_row(OP_TICK,       10'd1023, 1'b1, 31'h3F3F3F3F, 15'h3F3F, 1'b0);
    add_row(OP_START_STOP, 10'd1023, 1'b1, 31'h3F3F3F3F, 15'h3F3F, 1'b0);
    add_row(OP_SET_HUND,   10'd1,    1'b0, '0, '0, 1'b0);
    add_row(OP_TICK,       10'd0,    1'b0, '0, '0, 1'b0);
    add_row(OP_START_STOP, 10'd0,    1'b0, '0, '0, 1'b0);
    add_row(OP_TICK,       10'd0,    1'b0, '0, '0, 1'b0);
    add_row(OP_TICK,       10'd0,    1'b0, '0, '0, 1'b0);
    // saturation above each limit
    add_row(OP_SET_SEC,    10'd60,   1'b0, '0, '0, 1'b0);
    add_row(OP_SET_MIN,    10'd1023, 1'b0, '0, '0, 1'b0);
    add_row(OP_SET_HUND,   10'd100,  1'b0, '0, '0, 1'b0);
    add_row(OP_START_STOP, 10'd0,    1'b0, '0, '0, 1'b0);
    // borrow from minutes through seconds: 01:00:00 -> 00:59:99
    add_row(OP_SET_SEC,    10'd0,    1'b0, '0, '0, 1'b0);
    add_row(OP_SET_MIN,    10'd1,    1'b0, '0, '0, 1'b0);
    add_row(OP_SET_HUND,   10'd0,    1'b0, '0, '0, 1'b0);
    add_row(OP_TICK,       10'd0,    1'b0, '0, '0, 1'b0);
    add_row(OP_SPARE_A,    10'd1023, 1'b0, '0, '0, 1'b0);
    add_row(OP_SPARE_B,    10'd512,  1'b0, '0, '0, 1'b0);
    add_row(OP_SPARE_C,    10'd341,  1'b0, '0, '0, 1'b0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_beat(directed_rows[i].op, directed_rows[i].sw, directed_rows[i].typed,
                directed_rows[i].want);

    while (sent < RandomBeats) begin
      if (sent >= CalmAfter) calm = 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        countdown_burst(sent);
      end else begin
        random_beat();
        sent++;
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending_readouts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("countdown_timer_seven_segment: match");
    end else begin
      $display("countdown_timer_seven_segment: mismatch");
    end
    $finish;
  end

endmodule
